### hdl/tst_pkg.sv
// Shared types and constants of the tone slot timeout table.
package tst_pkg;

  localparam int SLOTS = 10;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PIN_W = 8;
  localparam int DUR_W = 31;
  localparam int TIME_W = 32;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WRITE,
    ST_STOP,
    ST_STOP_OUT,
    ST_TICK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [IDX_W-1:0]  idx;
    logic [PIN_W-1:0]  pin;
    logic [TIME_W-1:0] stop;
  } slot_wr_t;

endpackage

### hdl/tst_if.sv
// Handshake channels for the input items and the result items.
interface tst_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [tst_pkg::PIN_W-1:0]   pin;
  logic [tst_pkg::DUR_W-1:0]   duration_ms;

  modport source (output valid, action, pin, duration_ms, input ready);
  modport sink (input valid, action, pin, duration_ms, output ready);
endinterface

interface tst_out_if;
  logic                        valid;
  logic                        ready;
  logic [tst_pkg::PIN_W-1:0]   out_pin;
  logic                        drive_on;
  logic                        table_full;
  logic                        last;

  modport source (output valid, out_pin, drive_on, table_full, last, input ready);
  modport sink (input valid, out_pin, drive_on, table_full, last, output ready);
endinterface

### hdl/tst_slot_store.sv
// Slot storage: valid flags, pin numbers and stop times, one read port at the scan index.
module tst_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tst_pkg::slot_wr_t             wr,
  input  logic [tst_pkg::IDX_W-1:0]     rd_idx,
  output logic                          rd_valid,
  output logic [tst_pkg::PIN_W-1:0]     rd_pin,
  output logic [tst_pkg::TIME_W-1:0]    rd_stop
);

  logic [tst_pkg::SLOTS-1:0]      valid_r;
  logic [tst_pkg::PIN_W-1:0]      pin_r  [tst_pkg::SLOTS];
  logic [tst_pkg::TIME_W-1:0]     stop_r [tst_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.set) begin
      valid_r[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      valid_r[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      pin_r[wr.idx]  <= wr.pin;
      stop_r[wr.idx] <= wr.stop;
    end
  end

  assign rd_valid = valid_r[rd_idx];
  assign rd_pin   = pin_r[rd_idx];
  assign rd_stop  = stop_r[rd_idx];

endmodule

### hdl/tone_slot_timeout_table_unit.sv
// Top level of the tone slot timeout table: sequencer, shared adder and result register.
//
// Items arrive on in_ch and results leave on out_ch, both valid/ready channels;
// a transaction happens at a rising edge with valid and ready both high.
// A tick transaction advances the millisecond counter and turns off every slot
// whose stop time has been reached, one result per slot, the final one marked last.
// A start transaction reuses the slot holding the pin or the first free slot and
// gives one pin-on result; table_full is set when no slot was available.
// A stop transaction frees the slot holding the pin and, if there was one, gives one pin-off result.
// The slots are visited one per cycle through a single 32-bit adder, except while a tick
// scan is paused for a stalled receiver; in_ch.ready is high only while the block is idle,
// so a new item is taken only once the last is done. The unused action code gives no result.
// A start or stop result is loaded into the output register once its scan has visited
// every slot, and the final tick result once the tick scan has ended.
// Results pass through a one-entry output register; while it is held by a
// stalled receiver, the scan pauses before it would need to emit another result.
// A synchronous reset frees every slot, clears the millisecond counter and
// drops any pending result.
module tone_slot_timeout_table_unit (
  input logic       clk,
  input logic       rst_n,
  tst_in_if.sink    in_ch,
  tst_out_if.source out_ch
);

  tst_pkg::state_t                state_r, state_nxt;
  logic [tst_pkg::IDX_W-1:0]      idx_r;
  logic [tst_pkg::PIN_W-1:0]      pin_r;
  logic [tst_pkg::DUR_W-1:0]      dur_r;
  logic [tst_pkg::TIME_W-1:0]     now_r;
  logic                           m_hit_r, f_hit_r, stop_hit_r, pend_vld_r;
  logic [tst_pkg::IDX_W-1:0]      m_idx_r, f_idx_r;
  logic [tst_pkg::PIN_W-1:0]      pend_pin_r;
  logic                           out_valid_r, out_on_r, out_full_r, out_last_r;
  logic [tst_pkg::PIN_W-1:0]      out_pin_r;

  tst_pkg::slot_wr_t              wr;
  logic                           rd_valid;
  logic [tst_pkg::PIN_W-1:0]      rd_pin;
  logic [tst_pkg::TIME_W-1:0]     rd_stop;

  logic [tst_pkg::TIME_W-1:0]     alu_b, alu_sum;
  logic                           alu_cin;
  logic                           in_acc, out_free, idx_end, pin_hit, expired, stall;
  logic                           advance, push, push_on, push_full, push_last;
  logic [tst_pkg::PIN_W-1:0]      push_pin;

  tst_slot_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_idx   (idx_r),
    .rd_valid (rd_valid),
    .rd_pin   (rd_pin),
    .rd_stop  (rd_stop)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_end  = (idx_r == tst_pkg::IDX_W'(tst_pkg::SLOTS - 1));
  assign pin_hit  = rd_valid && (rd_pin == pin_r);

  // The shared adder increments the counter, tests expiry and forms stop times.
  always_comb begin
    unique case (state_r)
      tst_pkg::ST_TICK: begin
        alu_b   = ~rd_stop;
        alu_cin = 1'b1;
      end
      tst_pkg::ST_WRITE: begin
        alu_b   = {1'b0, dur_r};
        alu_cin = 1'b0;
      end
      default: begin
        alu_b   = '0;
        alu_cin = 1'b1;
      end
    endcase
  end

  assign alu_sum = now_r + alu_b + tst_pkg::TIME_W'(alu_cin);
  assign expired = rd_valid && !alu_sum[tst_pkg::TIME_W-1];
  assign stall   = expired && pend_vld_r && !out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tst_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == tst_pkg::ACT_TICK) begin
            state_nxt = tst_pkg::ST_TICK;
          end else if (in_ch.action == tst_pkg::ACT_START) begin
            state_nxt = tst_pkg::ST_START;
          end else if (in_ch.action == tst_pkg::ACT_STOP) begin
            state_nxt = tst_pkg::ST_STOP;
          end
        end
      end
      tst_pkg::ST_START: begin
        if (idx_end) begin
          state_nxt = tst_pkg::ST_WRITE;
        end
      end
      tst_pkg::ST_WRITE: begin
        if (out_free) begin
          state_nxt = tst_pkg::ST_IDLE;
        end
      end
      tst_pkg::ST_STOP: begin
        if (idx_end) begin
          state_nxt = (stop_hit_r || pin_hit) ? tst_pkg::ST_STOP_OUT : tst_pkg::ST_IDLE;
        end
      end
      tst_pkg::ST_STOP_OUT: begin
        if (out_free) begin
          state_nxt = tst_pkg::ST_IDLE;
        end
      end
      tst_pkg::ST_TICK: begin
        if (idx_end && !stall) begin
          state_nxt = tst_pkg::ST_FLUSH;
        end
      end
      tst_pkg::ST_FLUSH: begin
        if (!pend_vld_r || out_free) begin
          state_nxt = tst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    advance     = 1'b0;
    push        = 1'b0;
    push_pin    = pin_r;
    push_on     = 1'b0;
    push_full   = 1'b0;
    push_last   = 1'b1;
    wr.set      = 1'b0;
    wr.clr      = 1'b0;
    wr.idx      = idx_r;
    wr.pin      = pin_r;
    wr.stop     = alu_sum;
    unique case (state_r)
      tst_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      tst_pkg::ST_START: begin
        advance = 1'b1;
      end
      tst_pkg::ST_WRITE: begin
        if (out_free) begin
          push      = 1'b1;
          push_on   = 1'b1;
          push_full = !(m_hit_r || f_hit_r);
          wr.set    = m_hit_r || f_hit_r;
          wr.idx    = m_hit_r ? m_idx_r : f_idx_r;
        end
      end
      tst_pkg::ST_STOP: begin
        advance = 1'b1;
        wr.clr  = pin_hit;
      end
      tst_pkg::ST_STOP_OUT: begin
        push = out_free;
      end
      tst_pkg::ST_TICK: begin
        if (!stall) begin
          advance   = 1'b1;
          wr.clr    = expired;
          push      = expired && pend_vld_r;
          push_pin  = pend_pin_r;
          push_last = 1'b0;
        end
      end
      tst_pkg::ST_FLUSH: begin
        push     = pend_vld_r && out_free;
        push_pin = pend_pin_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tst_pkg::ST_IDLE;
      now_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && (in_ch.action == tst_pkg::ACT_TICK)) begin
        now_r <= alu_sum;
      end
      if (state_r == tst_pkg::ST_TICK && !stall && expired) begin
        pend_vld_r <= 1'b1;
      end else if (state_r == tst_pkg::ST_FLUSH && out_free) begin
        pend_vld_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r      <= '0;
      pin_r      <= in_ch.pin;
      dur_r      <= in_ch.duration_ms;
      m_hit_r    <= 1'b0;
      f_hit_r    <= 1'b0;
      stop_hit_r <= 1'b0;
    end else begin
      if (advance && !idx_end) begin
        idx_r <= idx_r + tst_pkg::IDX_W'(1);
      end
      if (state_r == tst_pkg::ST_START) begin
        if (pin_hit && !m_hit_r) begin
          m_hit_r <= 1'b1;
          m_idx_r <= idx_r;
        end
        if (!rd_valid && !f_hit_r) begin
          f_hit_r <= 1'b1;
          f_idx_r <= idx_r;
        end
      end
      if (state_r == tst_pkg::ST_STOP && pin_hit) begin
        stop_hit_r <= 1'b1;
      end
    end
    if (state_r == tst_pkg::ST_TICK && !stall && expired) begin
      pend_pin_r <= rd_pin;
    end
    if (push) begin
      out_pin_r  <= push_pin;
      out_on_r   <= push_on;
      out_full_r <= push_full;
      out_last_r <= push_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_pin    = out_pin_r;
  assign out_ch.drive_on   = out_on_r;
  assign out_ch.table_full = out_full_r;
  assign out_ch.last       = out_last_r;

`ifndef ASSERT_OFF
  a_write_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tst_pkg::ST_WRITE && out_free) |=> (out_valid_r && out_on_r && out_last_r))
    else $error("start result was not loaded into the output register");

  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == tst_pkg::ST_TICK || state_r == tst_pkg::ST_FLUSH))
    else $error("pending tick result outside of a tick scan");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tst_pkg::ST_TICK || state_r == tst_pkg::ST_START ||
     state_r == tst_pkg::ST_STOP) |-> (idx_r <= tst_pkg::IDX_W'(tst_pkg::SLOTS - 1)))
    else $error("scan index beyond the last slot");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.action == tst_pkg::ACT_TICK) |=> (now_r == $past(now_r) + 32'd1))
    else $error("millisecond counter did not advance on a tick");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !push)
    else $error("result register overwritten while the receiver stalls");
`endif

endmodule

### tb/tb_tone_slot_timeout_table_unit.sv
// Self-checking testbench for the tone slot timeout table, with its own shadow of the slot table.
`timescale 1ns / 100ps

module tb_tone_slot_timeout_table_unit;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 32;
  localparam int POOL_SIZE = 12;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [tst_pkg::PIN_W-1:0] pin;
    logic                      drive_on;
    logic                      table_full;
    logic                      last;
  } pin_change_t;

  class tone_table_shadow;
    bit                         slot_busy[tst_pkg::SLOTS];
    bit [tst_pkg::PIN_W-1:0]    slot_owner[tst_pkg::SLOTS];
    bit [tst_pkg::TIME_W-1:0]   slot_deadline[tst_pkg::SLOTS];
    bit [tst_pkg::TIME_W-1:0]   clock_ms;
    pin_change_t                pin_changes_due[$];
    int                         mismatches;

    function new();
      for (int i = 0; i < tst_pkg::SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        slot_owner[i] = '0;
        slot_deadline[i] = '0;
      end
      clock_ms = '0;
      mismatches = 0;
    endfunction

    function void push_change(input logic [tst_pkg::PIN_W-1:0] pin, input logic on,
                              input logic full);
      pin_change_t c;
      c.pin = pin;
      c.drive_on = on;
      c.table_full = full;
      c.last = 1'b0;
      pin_changes_due.push_back(c);
    endfunction

    function void apply_request(input logic [1:0] act, input logic [tst_pkg::PIN_W-1:0] pin,
                                input logic [tst_pkg::DUR_W-1:0] dur);
      int due_at_entry;
      int slot;
      bit hit;
      bit [tst_pkg::TIME_W-1:0] diff;
      due_at_entry = pin_changes_due.size();
      slot = -1;
      hit = 1'b0;
      if (act == tst_pkg::ACT_TICK) begin
        clock_ms = clock_ms + tst_pkg::TIME_W'(1);
        for (int i = 0; i < tst_pkg::SLOTS; i++) begin
          if (slot_busy[i]) begin
            diff = clock_ms - slot_deadline[i];
            if (!diff[tst_pkg::TIME_W-1]) begin
              push_change(slot_owner[i], 1'b0, 1'b0);
              slot_busy[i] = 1'b0;
            end
          end
        end
      end else if (act == tst_pkg::ACT_START) begin
        for (int i = 0; i < tst_pkg::SLOTS; i++) begin
          if (slot < 0 && slot_busy[i] && slot_owner[i] == pin) slot = i;
        end
        for (int i = 0; i < tst_pkg::SLOTS; i++) begin
          if (slot < 0 && !slot_busy[i]) slot = i;
        end
        if (slot >= 0) begin
          slot_busy[slot] = 1'b1;
          slot_owner[slot] = pin;
          slot_deadline[slot] = clock_ms + {1'b0, dur};
          push_change(pin, 1'b1, 1'b0);
        end else begin
          push_change(pin, 1'b1, 1'b1);
        end
      end else if (act == tst_pkg::ACT_STOP) begin
        for (int i = 0; i < tst_pkg::SLOTS; i++) begin
          if (slot_busy[i] && slot_owner[i] == pin) begin
            slot_busy[i] = 1'b0;
            hit = 1'b1;
          end
        end
        if (hit) push_change(pin, 1'b0, 1'b0);
      end
      if (pin_changes_due.size() > due_at_entry) begin
        pin_changes_due[pin_changes_due.size() - 1].last = 1'b1;
      end
    endfunction

    function void compare_pin_change(input pin_change_t got);
      pin_change_t want;
      if (pin_changes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: pin %0d on %0b full %0b last %0b",
                   got.pin, got.drive_on, got.table_full, got.last);
        end
      end else begin
        want = pin_changes_due.pop_front();
        if (want.pin !== got.pin || want.drive_on !== got.drive_on ||
            want.table_full !== got.table_full || want.last !== got.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected pin %0d on %0b full %0b last %0b, ",
                     want.pin, want.drive_on, want.table_full, want.last,
                     "got pin %0d on %0b full %0b last %0b",
                     got.pin, got.drive_on, got.table_full, got.last);
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tst_in_if  in_ch ();
  tst_out_if out_ch ();

  tone_slot_timeout_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tone_table_shadow shadow = new();

  int tx_idle_pct;
  int rx_idle_pct;
  bit long_hold_req;
  int quiet_cycles;
  logic [tst_pkg::PIN_W-1:0] pin_pool[POOL_SIZE];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pin_change_t got;
    bit moved;
    moved = 1'b0;
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) moved = 1'b1;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.pin = out_ch.out_pin;
      got.drive_on = out_ch.drive_on;
      got.table_full = out_ch.table_full;
      got.last = out_ch.last;
      shadow.compare_pin_change(got);
      moved = 1'b1;
    end
    if (moved) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_tone_slot_timeout_table_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] act, input logic [tst_pkg::PIN_W-1:0] pin,
                              input logic [tst_pkg::DUR_W-1:0] dur);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.pin <= pin;
    in_ch.duration_ms <= dur;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    shadow.apply_request(act, pin, dur);
  endtask

  task automatic send_random_requests(input int count);
    int done;
    int r;
    logic [1:0] act;
    logic [tst_pkg::PIN_W-1:0] pin;
    logic [tst_pkg::DUR_W-1:0] dur;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 45) act = tst_pkg::ACT_TICK;
      else if (r < 80) act = tst_pkg::ACT_START;
      else if (r < 97) act = tst_pkg::ACT_STOP;
      else act = ACT_UNUSED;
      if ($urandom_range(99) < 80) pin = pin_pool[$urandom_range(POOL_SIZE - 1)];
      else pin = tst_pkg::PIN_W'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 70) dur = tst_pkg::DUR_W'($urandom_range(15));
      else if (r < 90) dur = tst_pkg::DUR_W'($urandom_range(60));
      else dur = tst_pkg::DUR_W'($urandom());
      send_request(act, pin, dur);
      if (act != ACT_UNUSED) done++;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= tst_pkg::ACT_TICK;
    in_ch.pin <= '0;
    in_ch.duration_ms <= '0;
    quiet_cycles = 0;
    long_hold_req = 1'b0;
    tx_idle_pct = 21;
    rx_idle_pct = 61;
    for (int i = 0; i < POOL_SIZE; i++) pin_pool[i] = tst_pkg::PIN_W'($urandom_range(255));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(tst_pkg::ACT_TICK, 8'd0, 31'd0);
    send_request(tst_pkg::ACT_START, 8'd0, 31'd0);
    send_request(tst_pkg::ACT_TICK, 8'd0, 31'd0);
    send_request(tst_pkg::ACT_START, 8'd255, 31'h7FFF_FFFF);
    send_request(tst_pkg::ACT_START, 8'd255, 31'd3);
    send_request(tst_pkg::ACT_STOP, 8'h5A, 31'd0);
    send_request(tst_pkg::ACT_STOP, 8'd255, 31'h7FFF_FFFF);
    send_request(ACT_UNUSED, 8'd255, 31'h7FFF_FFFF);
    for (int i = 1; i <= tst_pkg::SLOTS; i++) begin
      send_request(tst_pkg::ACT_START, i[tst_pkg::PIN_W-1:0], tst_pkg::DUR_W'(i % 3));
    end
    send_request(tst_pkg::ACT_START, 8'd200, 31'd5);
    send_request(tst_pkg::ACT_START, 8'd3, 31'd7);
    send_request(tst_pkg::ACT_TICK, 8'd0, 31'd0);
    send_request(tst_pkg::ACT_TICK, 8'd0, 31'd0);
    send_request(tst_pkg::ACT_STOP, 8'd5, 31'd0);
    send_request(tst_pkg::ACT_TICK, 8'd0, 31'd0);

    send_random_requests(RANDOM_PER_PHASE);
    tx_idle_pct = 61;
    rx_idle_pct = 21;
    send_random_requests(RANDOM_PER_PHASE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_req = 1'b1;
    send_random_requests(RANDOM_PER_PHASE);
    in_ch.valid <= 1'b0;

    while (shadow.pin_changes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pin_changes_due.size() == 0) begin
      $display("tb_tone_slot_timeout_table_unit: PASS");
    end else begin
      $display("tb_tone_slot_timeout_table_unit: FAIL");
    end
    $finish;
  end

endmodule
